// ===== rtl/bdch_pkg.sv =====
// ----------------------------------------------------------------------------
// bdch_pkg
// Shared types and constants for the button debounce / click / hold block.
// ----------------------------------------------------------------------------
package bdch_pkg;

    // Configuration port geometry
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_MS     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MS   = 2'd3;

    // Register reset values
    localparam logic                  RST_ACTIVE_LOW  = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RST_DEBOUNCE_MS = 16'd50;
    localparam logic [CFG_DATA_W-1:0] RST_HOLD_MS     = 16'd500;
    localparam logic [CFG_DATA_W-1:0] RST_REPEAT_MS   = 16'd100;

    // Millisecond time base width
    localparam int TIME_W = 32;

    // Stream beat widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;

    // Configuration as seen by the event engine
    typedef struct packed {
        logic                  active_low;
        logic [CFG_DATA_W-1:0] debounce_ms;
        logic [CFG_DATA_W-1:0] hold_ms;
        logic [CFG_DATA_W-1:0] repeat_ms;
    } t_cfg;

    // One result beat
    typedef struct packed {
        logic repeat_pulse;
        logic holding;
        logic hold_event;
        logic click_event;
        logic pressed;
    } t_result;

endpackage

// ===== rtl/bdch_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bdch_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bdch_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bdch_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bdch_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output bdch_pkg::t_cfg                o_cfg
);
    import bdch_pkg::*;

    t_cfg r_cfg;

    // Write the addressed register, keep the rest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_low  <= RST_ACTIVE_LOW;
            r_cfg.debounce_ms <= RST_DEBOUNCE_MS;
            r_cfg.hold_ms     <= RST_HOLD_MS;
            r_cfg.repeat_ms   <= RST_REPEAT_MS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ACTIVE_LOW:  r_cfg.active_low  <= i_cfg_wdata[0];
                REG_DEBOUNCE_MS: r_cfg.debounce_ms <= i_cfg_wdata;
                REG_HOLD_MS:     r_cfg.hold_ms     <= i_cfg_wdata;
                REG_REPEAT_MS:   r_cfg.repeat_ms   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/bdch_in_stage.sv =====
// ----------------------------------------------------------------------------
// bdch_in_stage
// Input register for the pin sample stream.
// ----------------------------------------------------------------------------
module bdch_in_stage (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  logic i_pin,
    input  logic i_take,
    output logic o_valid,
    output logic o_pin
);
    logic r_valid;
    logic r_pin;

    // Accept when empty or when the held beat moves on this cycle
    assign o_ready = !r_valid || i_take;

    // Hold the valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Capture the sample
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_pin <= i_pin;
        end
    end

    assign o_valid = r_valid;
    assign o_pin   = r_pin;

endmodule

// ===== rtl/bdch_engine.sv =====
// ----------------------------------------------------------------------------
// bdch_engine
// Debounce, click, hold and repeat logic with its state and result register.
// ----------------------------------------------------------------------------
module bdch_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bdch_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  logic              i_pin,
    output logic              o_take,
    output logic              o_valid,
    input  logic              i_ready,
    output bdch_pkg::t_result o_result
);
    import bdch_pkg::*;

    logic [TIME_W-1:0] r_now;
    logic              r_deb;
    logic [TIME_W-1:0] r_last_change;
    logic [TIME_W-1:0] r_press_start;
    logic              r_hold_reported;
    logic              r_hold_active;
    logic [TIME_W-1:0] r_last_repeat;
    logic              r_out_valid;
    t_result           r_result;

    logic [TIME_W-1:0] n_last_change;
    logic [TIME_W-1:0] n_press_start;
    logic              n_deb;
    logic              n_hold_reported;
    logic              n_hold_active;
    logic [TIME_W-1:0] n_last_repeat;
    t_result           n_result;

    logic              w_level;
    logic [TIME_W-1:0] w_since_change;
    logic [TIME_W-1:0] w_since_press;
    logic [TIME_W-1:0] w_since_repeat;
    logic              w_change;
    logic              w_hold_ev;
    logic              w_rep;

    // Move a beat into the result register when it is free or being drained
    assign o_take = i_valid && (!r_out_valid || i_ready);

    // Elapsed times, all modulo 2^32
    assign w_level        = i_pin ^ i_cfg.active_low;
    assign w_since_change = r_now - r_last_change;
    assign w_since_press  = r_now - r_press_start;
    assign w_since_repeat = r_now - r_last_repeat;

    // Accept a new debounced level
    assign w_change = (w_level != r_deb) &&
                      (w_since_change > {{(TIME_W-CFG_DATA_W){1'b0}}, i_cfg.debounce_ms});

    // Next state and result for this tick
    always_comb begin
        n_deb           = r_deb;
        n_last_change   = r_last_change;
        n_press_start   = r_press_start;
        n_hold_reported = r_hold_reported;
        n_hold_active   = r_hold_active;
        n_last_repeat   = r_last_repeat;
        n_result        = '0;

        if (w_change) begin
            n_deb         = w_level;
            n_last_change = r_now;
            if (w_level) begin
                n_press_start   = r_now;
                n_hold_reported = 1'b0;
            end else begin
                n_result.click_event =
                    (w_since_press < {{(TIME_W-CFG_DATA_W){1'b0}}, i_cfg.hold_ms}) &&
                    !r_hold_reported;
                n_hold_active = 1'b0;
            end
        end

        // An accepted change restarts the change timer, so no hold then
        w_hold_ev = w_level && !w_change && !n_hold_active &&
                    (w_since_change > {{(TIME_W-CFG_DATA_W){1'b0}}, i_cfg.hold_ms});
        if (w_hold_ev) begin
            n_hold_active   = 1'b1;
            n_hold_reported = 1'b1;
        end

        w_rep = n_hold_active &&
                (w_since_repeat >= {{(TIME_W-CFG_DATA_W){1'b0}}, i_cfg.repeat_ms});
        if (w_rep) begin
            n_last_repeat = r_now;
        end

        n_result.pressed      = n_deb;
        n_result.hold_event   = w_hold_ev;
        n_result.holding      = n_hold_active;
        n_result.repeat_pulse = w_rep;
    end

    // Advance state and the output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now           <= '0;
            r_deb           <= 1'b0;
            r_last_change   <= '0;
            r_press_start   <= '0;
            r_hold_reported <= 1'b0;
            r_hold_active   <= 1'b0;
            r_last_repeat   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_take) begin
                r_now           <= r_now + 1'b1;
                r_deb           <= n_deb;
                r_last_change   <= n_last_change;
                r_press_start   <= n_press_start;
                r_hold_reported <= n_hold_reported;
                r_hold_active   <= n_hold_active;
                r_last_repeat   <= n_last_repeat;
                r_out_valid     <= 1'b1;
            end else if (i_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_result;

    // A hold event always starts a hold in progress
    a_hold_ev_holding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.hold_event) |-> r_result.holding)
        else $error("hold_event without holding");

    // Repeat pulses only come while holding
    a_rep_holding: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.repeat_pulse) |-> r_result.holding)
        else $error("repeat_pulse without holding");

    // A click is reported on an accepted release
    a_click_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_result.click_event) |-> (!r_result.pressed && !r_result.holding))
        else $error("click_event while pressed or holding");

    // Time base advances exactly once per processed beat
    a_now_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(o_take) |-> (r_now == $past(r_now) + 1'b1))
        else $error("time base did not advance with a beat");

endmodule

// ===== rtl/button_debounce_click_hold_core.sv =====
// ----------------------------------------------------------------------------
// button_debounce_click_hold_core
// Button debouncer with click, long-press hold and auto-repeat events.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one beat per millisecond tick, s_axis_tdata[0] = raw pin.
//   Master stream: one result beat per input beat, same order.
//   Config port: i_cfg_we / i_cfg_idx / i_cfg_wdata, written while idle;
//   index 0 active_low, 1 debounce_ms, 2 hold_ms, 3 repeat_ms.
// Path: an accepted beat is captured in the input register and moves into
//   the result register when that is free or being drained, from where it
//   is presented on m_axis.
// Throughput: one beat per cycle while m_axis_tready is high; the
//   single-pass event logic between the two registers sets that figure.
// Stall: when m_axis_tready is low the result register holds its beat, the
//   input register fills, and s_axis_tready drops only once both are full.
// Reset: synchronous active-low reset clears the millisecond counter, the
//   debounce/hold state and both valid flags, and loads the register
//   defaults (active_low 1, debounce 50, hold 500, repeat 100).
// ----------------------------------------------------------------------------
module button_debounce_click_hold_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Pin samples
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [bdch_pkg::IN_TDATA_W-1:0]     s_axis_tdata,  // [0] raw_pin
    // Results
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] pressed, [1] click_event, [2] hold_event, [3] holding, [4] repeat_pulse
    output logic [bdch_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration
    input  logic                                i_cfg_we,
    input  logic [bdch_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [bdch_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import bdch_pkg::*;

    t_cfg    w_cfg;
    t_result w_result;
    logic    w_stage_valid;
    logic    w_stage_pin;
    logic    w_take;

    // Configuration registers
    bdch_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // Input register
    bdch_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_pin   (s_axis_tdata[0]),
        .i_take  (w_take),
        .o_valid (w_stage_valid),
        .o_pin   (w_stage_pin)
    );

    // Event logic and result register
    bdch_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_valid  (w_stage_valid),
        .i_pin    (w_stage_pin),
        .o_take   (w_take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    // Pack the result beat, lowest field first
    assign m_axis_tdata = {{(OUT_TDATA_W-5){1'b0}},
                           w_result.repeat_pulse,
                           w_result.holding,
                           w_result.hold_event,
                           w_result.click_event,
                           w_result.pressed};

endmodule

// ===== sim/tb_button_debounce_click_hold_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_debounce_click_hold_core
// Streams millisecond pin samples into the debouncer under several timing
// settings. Each accepted tick goes through a local model of the debounce,
// click, hold and repeat rules, and every result beat is checked field by
// field, in order, against that prediction. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_button_debounce_click_hold_core;
    import bdch_pkg::*;

    localparam int LIMIT_CYCLES = 200_000;
    localparam int TAIL_CYCLES  = 8;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;   // [0] raw_pin
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // [0] pressed, [1] click_event, [2] hold_event, [3] holding, [4] repeat_pulse
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_wdata = '0;

    // Knobs for random idling on each side, in percent
    int unsigned src_gap_pct = 13;
    int unsigned sink_stall_pct = 13;

    int unsigned cycle_count = 0;
    int unsigned error_count = 0;
    int unsigned ticks_sent = 0;

    // Shadow of the block's registers and event state
    t_cfg        cfg_shadow = '{RST_ACTIVE_LOW, RST_DEBOUNCE_MS, RST_HOLD_MS, RST_REPEAT_MS};
    logic [31:0] tick_ms = '0;
    logic        settled_level = 1'b0;
    logic [31:0] last_edge_ms = '0;
    logic [31:0] press_ms = '0;
    logic        hold_seen = 1'b0;
    logic        hold_on = 1'b0;
    logic [31:0] last_pulse_ms = '0;

    t_result expected_events_q[$];

    button_debounce_click_hold_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Random backpressure on the result side
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Advance the event model by one tick and return the expected result
    function automatic t_result predict_button_events(input logic pin);
        t_result     r;
        logic        level;
        logic [31:0] since_edge;
        logic [31:0] since_press;
        logic [31:0] since_pulse;
        r = '0;
        level = cfg_shadow.active_low ? ~pin : pin;
        since_edge = tick_ms - last_edge_ms;
        if (level != settled_level && since_edge > {16'd0, cfg_shadow.debounce_ms}) begin
            settled_level = level;
            last_edge_ms = tick_ms;
            if (level) begin
                press_ms = tick_ms;
                hold_seen = 1'b0;
            end else begin
                since_press = tick_ms - press_ms;
                if (since_press < {16'd0, cfg_shadow.hold_ms} && !hold_seen)
                    r.click_event = 1'b1;
                hold_on = 1'b0;
            end
        end
        // Hold looks at this tick's level, not the settled one
        since_edge = tick_ms - last_edge_ms;
        if (level && since_edge > {16'd0, cfg_shadow.hold_ms} && !hold_on) begin
            r.hold_event = 1'b1;
            hold_on = 1'b1;
            hold_seen = 1'b1;
        end
        since_pulse = tick_ms - last_pulse_ms;
        if (hold_on && since_pulse >= {16'd0, cfg_shadow.repeat_ms}) begin
            last_pulse_ms = tick_ms;
            r.repeat_pulse = 1'b1;
        end
        r.pressed = settled_level;
        r.holding = hold_on;
        tick_ms = tick_ms + 32'd1;
        return r;
    endfunction

    task automatic check_field(input string name, input logic want, input logic got);
        if (want !== got) begin
            $error("%s mismatch: expected %0b, got %0b", name, want, got);
            error_count++;
        end
    endtask

    // Compare each result beat with the oldest pending prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[4:0]);
            if (expected_events_q.size() == 0) begin
                $error("result beat with no pending tick: %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_events_q.pop_front();
                check_field("pressed", want.pressed, got.pressed);
                check_field("click_event", want.click_event, got.click_event);
                check_field("hold_event", want.hold_event, got.hold_event);
                check_field("holding", want.holding, got.holding);
                check_field("repeat_pulse", want.repeat_pulse, got.repeat_pulse);
            end
        end
    end

    // Send one tick beat, idling at random first
    task automatic send_tick(input logic pin);
        while ($urandom_range(99) < src_gap_pct) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, pin};
        do @(posedge i_clk); while (!s_axis_tready);
        expected_events_q.push_back(predict_button_events(pin));
        ticks_sent++;
    endtask

    task automatic send_run(input logic pin, input int unsigned len);
        repeat (len) send_tick(pin);
    endtask

    task automatic send_noise(input int unsigned len);
        repeat (len) send_tick(1'($urandom_range(1)));
    endtask

    // Drop valid and wait until every predicted beat has come back
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_events_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            REG_ACTIVE_LOW:  cfg_shadow.active_low  = value[0];
            REG_DEBOUNCE_MS: cfg_shadow.debounce_ms = value;
            REG_HOLD_MS:     cfg_shadow.hold_ms     = value;
            REG_REPEAT_MS:   cfg_shadow.repeat_ms   = value;
            default: ;
        endcase
    endtask

    task automatic set_timing(input logic [CFG_DATA_W-1:0] al, input logic [CFG_DATA_W-1:0] deb,
                              input logic [CFG_DATA_W-1:0] hold, input logic [CFG_DATA_W-1:0] rep);
        write_reg(REG_ACTIVE_LOW, al);
        write_reg(REG_DEBOUNCE_MS, deb);
        write_reg(REG_HOLD_MS, hold);
        write_reg(REG_REPEAT_MS, rep);
    endtask

    // Bouncy presses and releases of random length, mixed with pin noise
    task automatic run_press_sequences(input int unsigned n_ticks);
        int unsigned start;
        int unsigned deb_c;
        int unsigned hold_c;
        int unsigned rep_c;
        logic        down;
        start  = ticks_sent;
        deb_c  = (cfg_shadow.debounce_ms > 20) ? 20 : cfg_shadow.debounce_ms;
        hold_c = (cfg_shadow.hold_ms > 40) ? 40 : cfg_shadow.hold_ms;
        rep_c  = (cfg_shadow.repeat_ms > 10) ? 10 : cfg_shadow.repeat_ms;
        down   = cfg_shadow.active_low ? 1'b0 : 1'b1;
        while (ticks_sent - start < n_ticks) begin
            if ($urandom_range(99) < 80) begin
                send_noise($urandom_range(4));
                send_run(down, $urandom_range(1, deb_c + hold_c + 4 * rep_c + 4));
                send_noise($urandom_range(4));
                send_run(~down, $urandom_range(deb_c + 1, deb_c + 10));
            end else begin
                send_noise($urandom_range(1, 8));
            end
        end
        wait_idle();
    endtask

    // Power-up register values: nothing settles within a few ticks
    task automatic test_reset_defaults();
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // Click, then a hold with a repeat pulse on every tick; active_low masked to 0
    task automatic test_click_hold_repeat();
        set_timing(16'hFFFE, 16'd0, 16'd2, 16'd0);
        send_tick(1'b1);
        send_tick(1'b0);
        send_run(1'b1, 5);
        send_tick(1'b0);
        wait_idle();
    endtask

    // Inverted wiring: low pin is a press
    task automatic test_active_low_click();
        write_reg(REG_ACTIVE_LOW, 16'hFFFF);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_idle();
    endtask

    // Debounce never expires, yet the raw level still triggers a hold
    task automatic test_stuck_debounce_hold();
        set_timing(16'h0000, 16'hFFFF, 16'd1, 16'hFFFF);
        send_run(1'b1, 4);
        send_run(1'b0, 2);
        wait_idle();
    endtask

    task automatic test_short_timing_random();
        set_timing(16'd1, 16'd3, 16'd12, 16'd4);
        run_press_sequences(150);
    endtask

    // Zero debounce, hold and repeat, with both sides running flat out
    task automatic test_zero_timing_burst();
        src_gap_pct = 0;
        sink_stall_pct = 0;
        set_timing(16'd0, 16'd0, 16'd0, 16'd0);
        run_press_sequences(100);
        src_gap_pct = 13;
        sink_stall_pct = 13;
    endtask

    task automatic test_random_timing();
        set_timing(16'd1, 16'($urandom_range(8)), 16'($urandom_range(30)),
                   16'($urandom_range(8)));
        run_press_sequences(150);
    endtask

    task automatic test_stuck_debounce_random();
        set_timing(16'd0, 16'hFFFF, 16'd10, 16'hFFFF);
        run_press_sequences(60);
    endtask

    // Every press is shorter than the hold time
    task automatic test_long_hold_clicks();
        set_timing(16'd0, 16'd2, 16'hFFFF, 16'd3);
        run_press_sequences(100);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_click_hold_repeat();
        test_active_low_click();
        test_stuck_debounce_hold();
        test_short_timing_random();
        test_zero_timing_burst();
        test_random_timing();
        test_stuck_debounce_random();
        test_long_hold_clicks();

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bdch_pkg.sv
rtl/bdch_cfg_regs.sv
rtl/bdch_in_stage.sv
rtl/bdch_engine.sv
rtl/button_debounce_click_hold_core.sv
sim/tb_button_debounce_click_hold_core.sv
